@@ src/rcpp_pkg.sv @@
// Shared package for the register command packet parser.
// Holds parameter defaults, field widths, input function codes, sensor register indexes and response frame constants.
// No dependencies.
`timescale 1ns / 1ps

package rcpp_pkg;

    // Parameter defaults
    localparam int DEF_REG_COUNT   = 128;
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_CHANNELS    = 8;
    localparam int DEF_MAX_PAYLOAD = 60;

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 7;
    localparam int SCHAN_W  = 3;
    localparam int SAMPLE_W = 16;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_LENGTH  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_BODY    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_VOLTAGE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CURRENT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESPOND = 3'd4;

    // Register indexes that carry a sensor channel
    localparam logic [BYTE_W-1:0] IDX_VOLTAGE = 8'h10;
    localparam logic [BYTE_W-1:0] IDX_CURRENT = 8'h11;

    // Response frame header
    localparam logic [BYTE_W-1:0] HDR_N   = 8'h4E;
    localparam logic [BYTE_W-1:0] HDR_R   = 8'h52;
    localparam logic [BYTE_W-1:0] HDR_VER = 8'h02;

endpackage

@@ src/rcpp_regfile.sv @@
// Register file for the register command packet parser.
// Synchronous memory with a per-entry written flag so that unwritten entries read zero.
// Depends on rcpp_pkg.
`timescale 1ns / 1ps

module rcpp_regfile #(
    parameter int REG_COUNT = rcpp_pkg::DEF_REG_COUNT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [rcpp_pkg::INDEX_W-1:0] wr_idx,
    input  logic [rcpp_pkg::BYTE_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [rcpp_pkg::BYTE_W-1:0]  rd_idx,
    output logic [rcpp_pkg::BYTE_W-1:0]  rd_data
);

    localparam int AW = $clog2(REG_COUNT);

    logic [rcpp_pkg::BYTE_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0]        written_reg;
    logic [rcpp_pkg::BYTE_W-1:0] rd_q_reg;
    logic                        hit_reg;
    logic                        wr_in_range;
    logic                        rd_in_range;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;

    // Decode indexes, ignore anything past the end of the file
    assign wr_in_range = {1'b0, wr_idx} < rcpp_pkg::BYTE_W'(REG_COUNT);
    assign rd_in_range = {1'b0, rd_idx} < 9'(REG_COUNT);
    assign wr_addr     = wr_idx[AW-1:0];
    assign rd_addr     = rd_idx[AW-1:0];

    // Write and read the storage array
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Track written entries, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in_range)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= rd_in_range && written_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? rd_q_reg : '0;

endmodule

@@ src/rcpp_queue.sv @@
// Read request queue for the register command packet parser.
// Synchronous memory with a fill count; entries past the count are never read.
// Depends on rcpp_pkg.
`timescale 1ns / 1ps

module rcpp_queue #(
    parameter int QUEUE_DEPTH = rcpp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  logic                                push,
    input  logic [rcpp_pkg::BYTE_W-1:0]         push_data,
    input  logic                                rd_en,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]      rd_addr,
    output logic [rcpp_pkg::BYTE_W-1:0]         rd_data,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    count
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [rcpp_pkg::BYTE_W-1:0] mem [QUEUE_DEPTH];
    logic [rcpp_pkg::BYTE_W-1:0] rd_data_reg;
    logic [QCW-1:0]              count_reg;
    logic [QCW-1:0]              count_next;
    logic                        room;

    assign room = count_reg < QCW'(QUEUE_DEPTH);

    // Append to the tail, drop when full
    always_ff @(posedge clk)
    begin
        if (push && room)
        begin
            mem[count_reg[QAW-1:0]] <= push_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Advance or empty the fill count
    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (push && room)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

@@ src/rcpp_sample.sv @@
// Voltage and current sample tables for the register command packet parser.
// One synchronous memory addressed by {table, channel}; channels wrap by a constant table.
// Depends on rcpp_pkg.
`timescale 1ns / 1ps

module rcpp_sample #(
    parameter int CHANNELS = rcpp_pkg::DEF_CHANNELS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          wr_current,
    input  logic [rcpp_pkg::SCHAN_W-1:0]  wr_chan,
    input  logic [rcpp_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic                          rd_current,
    input  logic [rcpp_pkg::BYTE_W-1:0]   rd_chan,
    output logic [rcpp_pkg::SAMPLE_W-1:0] rd_data
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAW   = CW + 1;
    localparam int SDEPTH = 1 << SAW;
    localparam int LUT_N = 1 << rcpp_pkg::BYTE_W;

    logic [CW-1:0]                 chan_lut [LUT_N];
    logic [rcpp_pkg::SAMPLE_W-1:0] mem [SDEPTH];
    logic [SDEPTH-1:0]             written_reg;
    logic [rcpp_pkg::SAMPLE_W-1:0] rd_q_reg;
    logic                          hit_reg;
    logic [SAW-1:0]                wr_addr;
    logic [SAW-1:0]                rd_addr;

    // Channel number modulo the channel count
    for (genvar g = 0; g < LUT_N; g++)
    begin : g_chan_lut
        assign chan_lut[g] = CW'(g % CHANNELS);
    end

    assign wr_addr = {wr_current, chan_lut[{5'b0, wr_chan}]};
    assign rd_addr = {rd_current, chan_lut[rd_chan]};

    // Write and read the storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // Track written entries, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? rd_q_reg : '0;

endmodule

@@ src/register_command_packet_parser.sv @@
// Register command packet parser, top level.
// Length, body and sensor requests may arrive back to back while the parser is idle.
// Respond: a measuring walk over the queue memory, four header bytes, then one queue fetch
// per entry before the payload bytes that the entry yields.
// Empty queue: one heartbeat byte. Reset clears control state; register file and sample
// tables read zero until written through per-entry flags, so no clearing pass is needed.
`timescale 1ns / 1ps

module register_command_packet_parser #(
    parameter int REG_COUNT   = rcpp_pkg::DEF_REG_COUNT,
    parameter int QUEUE_DEPTH = rcpp_pkg::DEF_QUEUE_DEPTH,
    parameter int CHANNELS    = rcpp_pkg::DEF_CHANNELS,
    parameter int MAX_PAYLOAD = rcpp_pkg::DEF_MAX_PAYLOAD
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rcpp_pkg::FUNC_W-1:0]   func,
    input  logic [rcpp_pkg::BYTE_W-1:0]   byte_value,
    input  logic [rcpp_pkg::SCHAN_W-1:0]  sample_channel,
    input  logic [rcpp_pkg::SAMPLE_W-1:0] sample_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rcpp_pkg::BYTE_W-1:0]   out_byte,
    output logic                          last,
    output logic                          heartbeat,
    output logic                          truncated
);

    localparam int QAW   = $clog2(QUEUE_DEPTH);
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int RAW_W = $clog2(2 * QUEUE_DEPTH + MAX_PAYLOAD + 1);
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int BW    = rcpp_pkg::BYTE_W;
    localparam int IW    = rcpp_pkg::INDEX_W;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_MEASURE = 9'b000000010,
        ST_HEART   = 9'b000000100,
        ST_HEAD    = 9'b000001000,
        ST_FETCH   = 9'b000010000,
        ST_ENTRY   = 9'b000100000,
        ST_REG     = 9'b001000000,
        ST_SAMP_HI = 9'b010000000,
        ST_SAMP_LO = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [BW-1:0]      bytes_left_reg, bytes_left_next;
    logic               expect_reg, expect_next;
    logic               pread_reg, pread_next;
    logic [IW-1:0]      pidx_reg, pidx_next;
    logic [QCW-1:0]     ptr_reg, ptr_next;
    logic               mvalid_reg, mvalid_next;
    logic               chan_next_reg, chan_next_next;
    logic [RAW_W-1:0]   raw_reg, raw_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               cut_reg, cut_next;
    logic [LEN_W-1:0]   sent_reg, sent_next;
    logic [1:0]         hidx_reg, hidx_next;
    logic [BW-1:0]      cmd_reg, cmd_next;

    logic               out_valid_reg, out_valid_next;
    logic [BW-1:0]      out_byte_reg, out_byte_next;
    logic               last_reg, last_next;
    logic               hb_reg, hb_next;
    logic               trunc_reg, trunc_next;

    logic               accept;
    logic               out_free;
    logic               emit_req;
    logic               emit_last;
    logic [BW-1:0]      emit_byte;
    logic               do_emit;
    logic               pay_last;
    logic               entry_special;

    logic               rf_wr_en;
    logic               rf_rd_en;
    logic [BW-1:0]      rf_rd_data;
    logic               q_clear;
    logic               q_push;
    logic [BW-1:0]      q_push_data;
    logic               q_rd_en;
    logic [BW-1:0]      q_rd_data;
    logic [QCW-1:0]     q_count;
    logic               s_wr_en;
    logic               s_rd_en;
    logic [rcpp_pkg::SAMPLE_W-1:0] s_rd_data;

    // Storage
    rcpp_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rf_wr_en),
        .wr_idx  (pidx_reg),
        .wr_data (byte_value),
        .rd_en   (rf_rd_en),
        .rd_idx  (q_rd_data),
        .rd_data (rf_rd_data)
    );

    rcpp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (q_clear),
        .push      (q_push),
        .push_data (q_push_data),
        .rd_en     (q_rd_en),
        .rd_addr   (ptr_reg[QAW-1:0]),
        .rd_data   (q_rd_data),
        .count     (q_count)
    );

    rcpp_sample #(
        .CHANNELS (CHANNELS)
    ) u_sample (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (s_wr_en),
        .wr_current (func == rcpp_pkg::FUNC_CURRENT),
        .wr_chan    (sample_channel),
        .wr_data    (sample_value),
        .rd_en      (s_rd_en),
        .rd_current (cmd_reg == rcpp_pkg::IDX_CURRENT),
        .rd_chan    (q_rd_data),
        .rd_data    (s_rd_data)
    );

    // Handshake
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign do_emit  = emit_req && out_free;
    assign pay_last = (sent_reg + 1'b1) == len_reg;

    assign entry_special = (q_rd_data == rcpp_pkg::IDX_VOLTAGE)
                        || (q_rd_data == rcpp_pkg::IDX_CURRENT);

    // Parse packet requests
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        expect_next     = expect_reg;
        pread_next      = pread_reg;
        pidx_next       = pidx_reg;
        rf_wr_en        = 1'b0;
        q_clear         = 1'b0;
        q_push          = 1'b0;
        q_push_data     = byte_value;
        s_wr_en         = 1'b0;
        if (accept)
        begin
            case (func)
                rcpp_pkg::FUNC_LENGTH:
                begin
                    q_clear         = 1'b1;
                    bytes_left_next = byte_value;
                    expect_next     = 1'b0;
                    pread_next      = 1'b0;
                end
                rcpp_pkg::FUNC_BODY:
                begin
                    if (bytes_left_reg != '0)
                    begin
                        bytes_left_next = bytes_left_reg - 1'b1;
                        if (!expect_reg)
                        begin
                            pidx_next   = byte_value[IW-1:0];
                            pread_next  = byte_value[BW-1];
                            expect_next = 1'b1;
                            q_push      = byte_value[BW-1];
                            q_push_data = {1'b0, byte_value[IW-1:0]};
                        end
                        else
                        begin
                            expect_next = 1'b0;
                            if (!pread_reg)
                            begin
                                rf_wr_en = 1'b1;
                            end
                            else if (({1'b0, pidx_reg} == rcpp_pkg::IDX_VOLTAGE)
                                  || ({1'b0, pidx_reg} == rcpp_pkg::IDX_CURRENT))
                            begin
                                q_push = 1'b1;
                            end
                        end
                    end
                end
                rcpp_pkg::FUNC_VOLTAGE, rcpp_pkg::FUNC_CURRENT:
                begin
                    s_wr_en = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sequence the response frame
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        mvalid_next    = 1'b0;
        chan_next_next = chan_next_reg;
        raw_next       = raw_reg;
        len_next       = len_reg;
        cut_next       = cut_reg;
        sent_next      = sent_reg;
        hidx_next      = hidx_reg;
        cmd_next       = cmd_reg;
        q_rd_en        = 1'b0;
        rf_rd_en       = 1'b0;
        s_rd_en        = 1'b0;
        emit_req       = 1'b0;
        emit_last      = 1'b0;
        emit_byte      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == rcpp_pkg::FUNC_RESPOND))
                begin
                    state_next     = ST_MEASURE;
                    ptr_next       = '0;
                    chan_next_next = 1'b0;
                    raw_next       = '0;
                end
            end
            ST_MEASURE:
            begin
                // Stream the queue and add up the payload length
                if (ptr_reg < q_count)
                begin
                    q_rd_en     = 1'b1;
                    ptr_next    = ptr_reg + 1'b1;
                    mvalid_next = 1'b1;
                end
                if (mvalid_reg)
                begin
                    if (chan_next_reg)
                    begin
                        raw_next       = raw_reg + RAW_W'(3);
                        chan_next_next = 1'b0;
                    end
                    else if (entry_special)
                    begin
                        raw_next       = raw_reg + RAW_W'(1);
                        chan_next_next = 1'b1;
                    end
                    else
                    begin
                        raw_next = raw_reg + RAW_W'(2);
                    end
                end
                if (!(ptr_reg < q_count) && !mvalid_reg)
                begin
                    if (q_count == '0)
                    begin
                        state_next = ST_HEART;
                    end
                    else
                    begin
                        state_next     = ST_HEAD;
                        cut_next       = raw_reg > RAW_W'(MAX_PAYLOAD);
                        len_next       = (raw_reg > RAW_W'(MAX_PAYLOAD))
                                       ? LEN_W'(MAX_PAYLOAD) : raw_reg[LEN_W-1:0];
                        ptr_next       = '0;
                        chan_next_next = 1'b0;
                        sent_next      = '0;
                        hidx_next      = '0;
                    end
                end
            end
            ST_HEART:
            begin
                emit_req  = 1'b1;
                emit_last = 1'b1;
                if (do_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_HEAD:
            begin
                emit_req = 1'b1;
                case (hidx_reg)
                    2'd0:    emit_byte = rcpp_pkg::HDR_N;
                    2'd1:    emit_byte = rcpp_pkg::HDR_R;
                    2'd2:    emit_byte = rcpp_pkg::HDR_VER;
                    default: emit_byte = BW'(len_reg);
                endcase
                if (do_emit)
                begin
                    hidx_next = hidx_reg + 1'b1;
                    if (hidx_reg == 2'd3)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                q_rd_en    = 1'b1;
                state_next = ST_ENTRY;
            end
            ST_ENTRY:
            begin
                // Emit the entry byte and start the data read it needs
                emit_req  = 1'b1;
                emit_byte = q_rd_data;
                emit_last = pay_last;
                if (chan_next_reg)
                begin
                    s_rd_en = 1'b1;
                end
                else if (!entry_special)
                begin
                    rf_rd_en = 1'b1;
                end
                if (do_emit)
                begin
                    sent_next = sent_reg + 1'b1;
                    if (pay_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (chan_next_reg)
                    begin
                        chan_next_next = 1'b0;
                        state_next     = ST_SAMP_HI;
                    end
                    else if (entry_special)
                    begin
                        cmd_next       = q_rd_data;
                        chan_next_next = 1'b1;
                        ptr_next       = ptr_reg + 1'b1;
                        state_next     = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_REG;
                    end
                end
            end
            ST_REG:
            begin
                emit_req  = 1'b1;
                emit_byte = rf_rd_data;
                emit_last = pay_last;
                if (do_emit)
                begin
                    sent_next  = sent_reg + 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = pay_last ? ST_IDLE : ST_FETCH;
                end
            end
            ST_SAMP_HI:
            begin
                emit_req  = 1'b1;
                emit_byte = s_rd_data[15:8];
                emit_last = pay_last;
                if (do_emit)
                begin
                    sent_next  = sent_reg + 1'b1;
                    state_next = pay_last ? ST_IDLE : ST_SAMP_LO;
                end
            end
            ST_SAMP_LO:
            begin
                emit_req  = 1'b1;
                emit_byte = s_rd_data[7:0];
                emit_last = pay_last;
                if (do_emit)
                begin
                    sent_next  = sent_reg + 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = pay_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        hb_next        = hb_reg;
        trunc_next     = trunc_reg;
        if (do_emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            last_next      = emit_last;
            hb_next        = (state_reg == ST_HEART);
            trunc_next     = (state_reg != ST_HEART) && cut_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bytes_left_reg <= '0;
            expect_reg     <= 1'b0;
            pread_reg      <= 1'b0;
            pidx_reg       <= '0;
            ptr_reg        <= '0;
            mvalid_reg     <= 1'b0;
            chan_next_reg  <= 1'b0;
            raw_reg        <= '0;
            len_reg        <= '0;
            cut_reg        <= 1'b0;
            sent_reg       <= '0;
            hidx_reg       <= '0;
            cmd_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bytes_left_reg <= bytes_left_next;
            expect_reg     <= expect_next;
            pread_reg      <= pread_next;
            pidx_reg       <= pidx_next;
            ptr_reg        <= ptr_next;
            mvalid_reg     <= mvalid_next;
            chan_next_reg  <= chan_next_next;
            raw_reg        <= raw_next;
            len_reg        <= len_next;
            cut_reg        <= cut_next;
            sent_reg       <= sent_next;
            hidx_reg       <= hidx_next;
            cmd_reg        <= cmd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        hb_reg       <= hb_next;
        trunc_reg    <= trunc_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign heartbeat = hb_reg;
    assign truncated = trunc_reg;

endmodule
